>>> sv/asac_pkg.sv
// ----------------------------------------------------------------------------
// asac_pkg
// Shared types and constants of the analog stick auto-calibrating scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package asac_pkg;

    // number of joystick ports and the width of a port number
    localparam int NUM_PORTS = 2;
    localparam int PORT_W    = 1;
    localparam logic [PORT_W:0] PORT_LIMIT = (PORT_W + 1)'(NUM_PORTS);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = NUM_PORTS;

    // job queue between front and back, depth a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;

    // axis value for a zero span
    localparam logic [7:0] AXIS_MID = 8'd128;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_ENABLE = 2'd0,
        CFG_SWAP_XY     = 2'd1,
        CFG_INVERT_X    = 2'd2,
        CFG_INVERT_Y    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

    // input word
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [15:0]       pot_word;
        logic [15:0]       joy_word;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [7:0]        axis_x;
        logic [7:0]        axis_y;
        logic [1:0]        buttons;
        logic              valid_res;
    } t_out_word;

    // classified sample handed from front to back
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [7:0]        vx;
        logic [7:0]        vy;
        logic [7:0]        min_x;
        logic [7:0]        max_x;
        logic [7:0]        min_y;
        logic [7:0]        max_y;
        logic [1:0]        buttons;
        logic              inv_x;
        logic              inv_y;
        logic              calib;
    } t_job;

    // queue status seen by a consumer
    typedef struct packed {
        logic empty;
        t_job head;
    } t_q_status;

endpackage

`default_nettype wire

>>> sv/asac_fifo.sv
// ----------------------------------------------------------------------------
// asac_fifo
// Short job queue between the sample front end and the scaling back end.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_fifo
    import asac_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_job      i_job,
    input  wire logic      i_pop,
    output logic           o_full,
    output t_q_status      o_status
);

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full          = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_status.empty;

    // pointers and fill count, pointers wrap on their own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> sv/asac_front.sv
// ----------------------------------------------------------------------------
// asac_front
// Accepts samples, applies port enable and swap, widens the per-port
// min/max and queues a classified job for the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_front
    import asac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire t_in_word             i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_job                      o_job
);

    logic [CFG_W-1:0] r_port_en;
    logic [CFG_W-1:0] r_swap;
    logic [CFG_W-1:0] r_inv_x;
    logic [CFG_W-1:0] r_inv_y;

    logic [7:0] r_min_x [NUM_PORTS];
    logic [7:0] r_max_x [NUM_PORTS];
    logic [7:0] r_min_y [NUM_PORTS];
    logic [7:0] r_max_y [NUM_PORTS];

    logic [7:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic [7:0] vx, vy;
    logic       b1, b2;
    logic       port_ok;
    logic       accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_en <= '0;
            r_swap    <= '0;
            r_inv_x   <= '0;
            r_inv_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PORT_ENABLE: r_port_en <= i_cfg_wdata;
                CFG_SWAP_XY:     r_swap    <= i_cfg_wdata;
                CFG_INVERT_X:    r_inv_x   <= i_cfg_wdata;
                CFG_INVERT_Y:    r_inv_y   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify the sample
    always_comb begin
        accept  = i_push && !i_q_full;
        port_ok = ({1'b0, i_in.port} < PORT_LIMIT);
        vx      = i_in.pot_word[7:0];
        vy      = i_in.pot_word[15:8];
        b1      = i_in.joy_word[1];
        b2      = i_in.joy_word[9];
        if (r_swap[i_in.port]) begin
            vx = i_in.pot_word[15:8];
            vy = i_in.pot_word[7:0];
            b1 = i_in.joy_word[9];
            b2 = i_in.joy_word[1];
        end

        // widened bounds
        n_min_x = (vx < r_min_x[i_in.port]) ? vx : r_min_x[i_in.port];
        n_max_x = (vx > r_max_x[i_in.port]) ? vx : r_max_x[i_in.port];
        n_min_y = (vy < r_min_y[i_in.port]) ? vy : r_min_y[i_in.port];
        n_max_y = (vy > r_max_y[i_in.port]) ? vy : r_max_y[i_in.port];

        o_q_push = accept && port_ok && r_port_en[i_in.port];

        o_job.port    = i_in.port;
        o_job.vx      = vx;
        o_job.vy      = vy;
        o_job.min_x   = n_min_x;
        o_job.max_x   = n_max_x;
        o_job.min_y   = n_min_y;
        o_job.max_y   = n_max_y;
        o_job.buttons = {b2, b1};
        o_job.inv_x   = r_inv_x[i_in.port];
        o_job.inv_y   = r_inv_y[i_in.port];
        o_job.calib   = (n_max_x > n_min_x) || (n_max_y > n_min_y);
    end

    // per-port running bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_min_x[p] <= 8'hff;
                r_max_x[p] <= 8'h00;
                r_min_y[p] <= 8'hff;
                r_max_y[p] <= 8'h00;
            end
        end else if (o_q_push) begin
            r_min_x[i_in.port] <= n_min_x;
            r_max_x[i_in.port] <= n_max_x;
            r_min_y[i_in.port] <= n_min_y;
            r_max_y[i_in.port] <= n_max_y;
        end
    end

endmodule

`default_nettype wire

>>> sv/asac_back.sv
// ----------------------------------------------------------------------------
// asac_back
// Scales both axes of calibrated jobs with two radix-2 restoring dividers
// side by side, then loads the result into a one-word output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asac_back
    import asac_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q,
    output logic           o_q_pop,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_out_word      o_out
);

    t_back_state           r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_cnt;
    t_job                  r_job;
    logic [7:0]            r_rem_x, r_rem_y;
    logic [7:0]            r_low_x, r_low_y;
    logic [7:0]            r_quo_x, r_quo_y;
    logic                  r_out_full;
    t_out_word             r_out;

    logic [7:0]  dx, dy;
    logic [15:0] num_x, num_y;
    logic [8:0]  trial_x, trial_y;
    logic [7:0]  span_x, span_y;
    logic        ge_x, ge_y;
    logic        load;
    logic        finish;
    t_out_word   res;

    assign o_empty = !r_out_full;
    assign o_out   = r_out;

    // numerators (v - min) * 255, from the queue head
    always_comb begin
        dx    = i_q.head.vx - i_q.head.min_x;
        dy    = i_q.head.vy - i_q.head.min_y;
        num_x = {dx, 8'h00} - {8'h00, dx};
        num_y = {dy, 8'h00} - {8'h00, dy};
    end

    // one divider step per lane
    always_comb begin
        span_x  = r_job.max_x - r_job.min_x;
        span_y  = r_job.max_y - r_job.min_y;
        trial_x = {r_rem_x, r_low_x[7]};
        trial_y = {r_rem_y, r_low_y[7]};
        ge_x    = (trial_x >= {1'b0, span_x});
        ge_y    = (trial_y >= {1'b0, span_y});
    end

    // result formatting
    always_comb begin
        res.out_port = r_job.port;
        res.axis_x   = '0;
        res.axis_y   = '0;
        res.buttons  = '0;
        res.valid_res = 1'b0;
        if (r_job.calib) begin
            res.axis_x = (r_job.max_x <= r_job.min_x) ? AXIS_MID :
                         (r_job.inv_x ? ~r_quo_x : r_quo_x);
            res.axis_y = (r_job.max_y <= r_job.min_y) ? AXIS_MID :
                         (r_job.inv_y ? ~r_quo_y : r_quo_y);
            res.buttons   = r_job.buttons;
            res.valid_res = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        finish  = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q.empty) begin
                    o_q_pop = 1'b1;
                    load    = 1'b1;
                    n_state = i_q.head.calib ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_full || i_pop) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider datapath, numerator top byte is below the span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= '0;
        end else if (r_state == ST_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job   <= i_q.head;
            r_rem_x <= num_x[15:8];
            r_low_x <= num_x[7:0];
            r_rem_y <= num_y[15:8];
            r_low_y <= num_y[7:0];
            r_quo_x <= '0;
            r_quo_y <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem_x <= ge_x ? 8'(trial_x - {1'b0, span_x}) : trial_x[7:0];
            r_rem_y <= ge_y ? 8'(trial_y - {1'b0, span_y}) : trial_y[7:0];
            r_low_x <= {r_low_x[6:0], 1'b0};
            r_low_y <= {r_low_y[6:0], 1'b0};
            r_quo_x <= {r_quo_x[6:0], ge_x};
            r_quo_y <= {r_quo_y[6:0], ge_y};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (finish) begin
            r_out_full <= 1'b1;
        end else if (i_pop) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

>>> sv/analog_stick_autocalibrate_top.sv
// ----------------------------------------------------------------------------
// analog_stick_autocalibrate_top
// Jobs with calibrated bounds pass through the 8-step divider in the back end,
// other jobs skip it; the back end scales one word at a time.
// The front end takes a word every cycle until the 2-entry job queue fills.
// Reset: synchronous active low; bounds go to min 255 / max 0, all config 0.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_stick_autocalibrate_top
    import asac_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in_word             i_in,
    input  wire logic                 pop,
    output logic                      empty,
    output t_out_word                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    logic      q_push;
    logic      q_pop;
    t_job      job;
    t_q_status q_status;

    // sample classification and bounds
    asac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (full),
        .o_q_push    (q_push),
        .o_job       (job)
    );

    // job queue
    asac_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (job),
        .i_pop    (q_pop),
        .o_full   (full),
        .o_status (q_status)
    );

    // scaling and result register
    asac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_status),
        .o_q_pop (q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
